// ----- rtl/core/segment_rectilinear_polygon_hit_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the segment/polygon hit unit
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RECTILINEAR_POLYGON_HIT_UNIT_DEFINES_SVH
`define SEGMENT_RECTILINEAR_POLYGON_HIT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define SRPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and masked during reset.
`define SRPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/srph_pkg.sv -----
// ----------------------------------------------------------------------------
// srph_pkg
// Shared types and constants of the segment/polygon hit unit.
// ----------------------------------------------------------------------------
package srph_pkg;

    // Width of every coordinate field on the stream ports.
    localparam int FIELD_BITS  = 16;
    localparam int OPCODE_BITS = 2;

    // Latency of the edge test pipeline, drained after the ring sweep.
    localparam int DRAIN_CYCLES = 3;

    // Operation carried in the sideband of an input beat.
    typedef enum logic [OPCODE_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    // Per-cell control: rotate the ring or load a new vertex.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

// ----- rtl/core/segment_rectilinear_polygon_hit_unit.sv -----
// ----------------------------------------------------------------------------
// segment_rectilinear_polygon_hit_unit
// Polygon vertex store held in a rotating ring of cells; a query segment is
// tested against every axis-aligned edge of every closed polygon.
// ----------------------------------------------------------------------------
//
// Channel | Beat carries                                      | Handshake
// --------+---------------------------------------------------+--------------
// s_axis  | tuser: opcode; tlast: closes_polygon; tdata: rest | tvalid/tready
// m_axis  | tdata: hit, status                                | tvalid/tready
//
// For clear, append and unused opcodes the result lands in the output
// register on the accepting edge when that register is free.
// A query holds off the input through the accepting cycle, one turn of the
// vertex ring (one vertex per cycle), the edge pipeline drain and the post state.
// Reset empties the store; cell contents are not cleared.
// A stalled output holds its beat; one more input beat is taken, then input waits.
//
`include "segment_rectilinear_polygon_hit_unit_defines.svh"

module segment_rectilinear_polygon_hit_unit
    import srph_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // vertex_x, vertex_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
    input  logic [6*FIELD_BITS-1:0]  s_axis_tdata,
    // opcode
    input  logic [OPCODE_BITS-1:0]   s_axis_tuser,
    input  logic                     s_axis_tlast,

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // hit, status, six zero pad bits
    output logic [7:0]               m_axis_tdata
);

    localparam int CW    = COORD_BITS;
    localparam int CNTW  = $clog2(MAX_POINTS + 1);
    localparam int IW    = $clog2(MAX_POINTS);
    localparam int EW    = (CW > FIELD_BITS) ? CW : FIELD_BITS;
    localparam int CELLW = 2 * CW + 1;
    localparam int DRW   = $clog2(DRAIN_CYCLES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_POST  = 4'b1000
    } state_t;

    // Low COORD_BITS of a field, read as two's complement.
    function automatic logic signed [CW-1:0] to_coord(input logic [FIELD_BITS-1:0] f);
        logic [EW-1:0] e;
        e = EW'(f);
        return e[CW-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [CNTW-1:0]     stored_count_reg, stored_count_next;
    logic [CNTW-1:0]     closed_end_reg, closed_end_next;
    logic [IW-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [DRW-1:0]      drain_cnt_reg, drain_cnt_next;
    logic                first_reg, first_next;
    logic                hit_acc_reg, hit_acc_next;
    logic                res_hit_reg, res_hit_next;
    logic                res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg, out_hit_next;
    logic                out_status_reg, out_status_next;

    logic signed [CW-1:0] ax_reg, ay_reg;
    logic signed [CW:0]   dx_reg, dy_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;
    logic signed [CW-1:0] start_x_reg, start_y_reg;

    logic                in_acc;
    opcode_t             opcode;
    logic                full;
    logic                out_free;
    logic                append_load;
    logic                scanning;
    logic                vertex_act;
    logic                seg_load;

    logic signed [CW-1:0] in_vx, in_vy, in_sx, in_sy, in_ex, in_ey;
    logic signed [CW-1:0] cur_x, cur_y;
    logic                cur_mark;
    logic signed [CW-1:0] close_x, close_y;
    logic                hit_a, hit_b;

    logic [CELLW-1:0]    cell_data [MAX_POINTS];
    cell_ctl_t           cell_ctl  [MAX_POINTS];
    logic [CELLW-1:0]    load_data;

    // Input beat decode.
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign opcode   = opcode_t'(s_axis_tuser);
    assign in_vx    = to_coord(s_axis_tdata[1*FIELD_BITS-1:0*FIELD_BITS]);
    assign in_vy    = to_coord(s_axis_tdata[2*FIELD_BITS-1:1*FIELD_BITS]);
    assign in_sx    = to_coord(s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS]);
    assign in_sy    = to_coord(s_axis_tdata[4*FIELD_BITS-1:3*FIELD_BITS]);
    assign in_ex    = to_coord(s_axis_tdata[5*FIELD_BITS-1:4*FIELD_BITS]);
    assign in_ey    = to_coord(s_axis_tdata[6*FIELD_BITS-1:5*FIELD_BITS]);
    assign load_data = {s_axis_tlast, in_vy, in_vx};

    assign full     = (stored_count_reg == CNTW'(MAX_POINTS));
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign append_load = in_acc && (opcode == OP_APPEND) && !full;
    assign seg_load    = in_acc && (opcode == OP_QUERY);
    assign scanning    = (state_reg == ST_SCAN);

    // Ring of vertex cells; cell 0 is the head seen by the edge testers.
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % MAX_POINTS;

        assign cell_ctl[i].shift = scanning;
        assign cell_ctl[i].load  = append_load && (stored_count_reg[IW-1:0] == IW'(i));

        srph_cell #(
            .WIDTH (CELLW)
        ) u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[i]),
            .load_data (load_data),
            .ring_in   (cell_data[NXT]),
            .data      (cell_data[i])
        );
    end

    // Head vertex; only vertices of closed polygons form edges.
    assign cur_x      = cell_data[0][CW-1:0];
    assign cur_y      = cell_data[0][2*CW-1:CW];
    assign cur_mark   = cell_data[0][2*CW];
    assign vertex_act = scanning && (CNTW'(scan_cnt_reg) < closed_end_reg);
    assign close_x    = first_reg ? cur_x : start_x_reg;
    assign close_y    = first_reg ? cur_y : start_y_reg;

    // Edge from the previous vertex to the head vertex.
    srph_edge #(
        .CW (CW)
    ) u_edge_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vertex_act && !first_reg),
        .px       (prev_x_reg),
        .py       (prev_y_reg),
        .qx       (cur_x),
        .qy       (cur_y),
        .ax       (ax_reg),
        .ay       (ay_reg),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .hit      (hit_a)
    );

    // Closing edge from a polygon's last vertex back to its first.
    srph_edge #(
        .CW (CW)
    ) u_edge_close (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vertex_act && cur_mark),
        .px       (cur_x),
        .py       (cur_y),
        .qx       (close_x),
        .qy       (close_y),
        .ax       (ax_reg),
        .ay       (ay_reg),
        .dx       (dx_reg),
        .dy       (dy_reg),
        .hit      (hit_b)
    );

    // Sequencer and output register control.
    always_comb
    begin
        state_next        = state_reg;
        stored_count_next = stored_count_reg;
        closed_end_next   = closed_end_reg;
        scan_cnt_next     = scan_cnt_reg;
        drain_cnt_next    = drain_cnt_reg;
        first_next        = first_reg;
        hit_acc_next      = hit_acc_reg | hit_a | hit_b;
        res_hit_next      = res_hit_reg;
        res_status_next   = res_status_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_hit_next      = out_hit_reg;
        out_status_next   = out_status_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_hit_next    = 1'b0;
                    res_status_next = 1'b0;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            stored_count_next = '0;
                            closed_end_next   = '0;
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                stored_count_next = stored_count_reg + 1'b1;
                                if (s_axis_tlast)
                                begin
                                    closed_end_next = stored_count_reg + 1'b1;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            scan_cnt_next = '0;
                            first_next    = 1'b1;
                            hit_acc_next  = 1'b0;
                        end
                        default:
                        begin
                            res_status_next = 1'b0;
                        end
                    endcase

                    if (opcode == OP_QUERY)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_hit_next    = 1'b0;
                        out_status_next = res_status_next;
                    end
                    else
                    begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (vertex_act)
                begin
                    first_next = cur_mark;
                end
                if (scan_cnt_reg == IW'(MAX_POINTS - 1))
                begin
                    drain_cnt_next = '0;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_cnt_next = drain_cnt_reg + 1'b1;
                if (drain_cnt_reg == DRW'(DRAIN_CYCLES - 1))
                begin
                    res_hit_next    = hit_acc_next;
                    res_status_next = 1'b0;
                    state_next      = ST_POST;
                end
            end
            ST_POST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_hit_next    = res_hit_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stored_count_reg <= '0;
            closed_end_reg   <= '0;
            scan_cnt_reg     <= '0;
            drain_cnt_reg    <= '0;
            first_reg        <= 1'b1;
            hit_acc_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stored_count_reg <= stored_count_next;
            closed_end_reg   <= closed_end_next;
            scan_cnt_reg     <= scan_cnt_next;
            drain_cnt_reg    <= drain_cnt_next;
            first_reg        <= first_next;
            hit_acc_reg      <= hit_acc_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result and segment payload.
    always_ff @(posedge clk)
    begin
        res_hit_reg    <= res_hit_next;
        res_status_reg <= res_status_next;
        out_hit_reg    <= out_hit_next;
        out_status_reg <= out_status_next;
        if (seg_load)
        begin
            ax_reg <= in_sx;
            ay_reg <= in_sy;
            dx_reg <= {in_ex[CW-1], in_ex} - {in_sx[CW-1], in_sx};
            dy_reg <= {in_ey[CW-1], in_ey} - {in_sy[CW-1], in_sy};
        end
    end

    // Polygon walk: previous vertex and first vertex of the open polygon.
    always_ff @(posedge clk)
    begin
        if (vertex_act)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
            if (first_reg)
            begin
                start_x_reg <= cur_x;
                start_y_reg <= cur_y;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_status_reg, out_hit_reg};

    // Checks.
    `SRPH_ASSERT_NOW(a_count_order, 1'b1,
        (closed_end_reg <= stored_count_reg) && (stored_count_reg <= CNTW'(MAX_POINTS)),
        "vertex counts out of order")
    `SRPH_ASSERT_NEXT(a_query_start, seg_load,
        (state_reg == ST_SCAN) && (scan_cnt_reg == '0) && first_reg,
        "query did not start a ring sweep")
    `SRPH_ASSERT_NOW(a_post_source, $rose(m_axis_tvalid),
        $past(state_reg == ST_IDLE || state_reg == ST_POST),
        "result beat raised outside idle or post")

endmodule

// ----- rtl/core/srph_cell.sv -----
// ----------------------------------------------------------------------------
// srph_cell
// One vertex slot of the ring: loads an appended vertex or takes its
// neighbor's vertex while the ring rotates.
// ----------------------------------------------------------------------------
module srph_cell
    import srph_pkg::*;
#(
    parameter int WIDTH = 33
)
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [WIDTH-1:0] load_data,
    input  logic [WIDTH-1:0] ring_in,
    output logic [WIDTH-1:0] data
);

    logic [WIDTH-1:0] data_reg;

    // Vertex storage; contents are meaningless until written.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= ring_in;
        end
        else if (ctl.load)
        begin
            data_reg <= load_data;
        end
    end

    assign data = data_reg;

endmodule

// ----- rtl/core/srph_edge.sv -----
// ----------------------------------------------------------------------------
// srph_edge
// Three-stage test of one axis-aligned edge against the query segment:
// classify and span check, cross products, sign compare.
// ----------------------------------------------------------------------------
module srph_edge
#(
    parameter int CW = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [CW-1:0] px,
    input  logic signed [CW-1:0] py,
    input  logic signed [CW-1:0] qx,
    input  logic signed [CW-1:0] qy,
    input  logic signed [CW-1:0] ax,
    input  logic signed [CW-1:0] ay,
    input  logic signed [CW:0]   dx,
    input  logic signed [CW:0]   dy,
    output logic                hit
);

    localparam int PW = 2 * CW + 2;

    logic                vert;
    logic                horiz;
    logic signed [CW-1:0] pu;
    logic signed [CW-1:0] pv;
    logic signed [CW-1:0] qv;
    logic signed [CW-1:0] au;
    logic signed [CW-1:0] av;
    logic signed [CW:0]   du;
    logic signed [CW:0]   dv;
    logic signed [CW:0]   t_c;
    logic signed [CW:0]   e1_c;
    logic signed [CW:0]   e2_c;
    logic                span_ok;

    logic                v1_reg;
    logic signed [CW:0]   e1_reg;
    logic signed [CW:0]   e2_reg;
    logic signed [CW:0]   t_reg;
    logic signed [CW:0]   du_reg;
    logic signed [CW:0]   dv_reg;

    logic                v2_reg;
    logic signed [PW-1:0] pa_reg;
    logic signed [PW-1:0] pb_reg;
    logic signed [PW-1:0] pt_reg;

    logic signed [PW:0]   s1_c;
    logic signed [PW:0]   s2_c;
    logic                s1_pos;
    logic                s1_neg;
    logic                s2_pos;
    logic                s2_neg;
    logic                hit_reg;

    // Pick the fixed axis (u) and the spanned axis (v) of the edge.
    always_comb
    begin
        vert  = (px == qx);
        horiz = !vert && (py == qy);
        pu    = vert ? px : py;
        pv    = vert ? py : px;
        qv    = vert ? qy : qx;
        au    = vert ? ax : ay;
        av    = vert ? ay : ax;
        du    = vert ? dx : dy;
        dv    = vert ? dy : dx;
        t_c   = {pu[CW-1], pu} - {au[CW-1], au};
        e1_c  = {pv[CW-1], pv} - {av[CW-1], av};
        e2_c  = {qv[CW-1], qv} - {av[CW-1], av};
    end

    // The segment's span along u must strictly contain the edge position.
    always_comb
    begin
        if (du[CW])
        begin
            span_ok = t_c[CW] && (t_c > du);
        end
        else if (du != '0)
        begin
            span_ok = !t_c[CW] && (t_c != '0) && (t_c < du);
        end
        else
        begin
            span_ok = 1'b0;
        end
    end

    // Stage one: operands of the cross products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid && (vert || horiz) && span_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_reg <= e1_c;
        e2_reg <= e2_c;
        t_reg  <= t_c;
        du_reg <= du;
        dv_reg <= dv;
    end

    // Stage two: the three products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= e1_reg * du_reg;
        pb_reg <= e2_reg * du_reg;
        pt_reg <= t_reg * dv_reg;
    end

    // Stage three: the edge ends must lie on opposite sides of the crossing.
    always_comb
    begin
        s1_c   = {pa_reg[PW-1], pa_reg} - {pt_reg[PW-1], pt_reg};
        s2_c   = {pb_reg[PW-1], pb_reg} - {pt_reg[PW-1], pt_reg};
        s1_neg = s1_c[PW];
        s1_pos = !s1_c[PW] && (s1_c != '0);
        s2_neg = s2_c[PW];
        s2_pos = !s2_c[PW] && (s2_c != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= v2_reg && ((s1_pos && s2_neg) || (s1_neg && s2_pos));
        end
    end

    assign hit = hit_reg;

endmodule

// ----- dv/tb_segment_rectilinear_polygon_hit_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for segment_rectilinear_polygon_hit_unit
// Loads rectilinear polygons into the vertex store, fires query segments at
// them and checks every result beat against a cycle-free predictor of the
// edge-crossing test. A directed table comes first, then random polygon and
// query traffic under three idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module tb_segment_rectilinear_polygon_hit_unit;
    import srph_pkg::*;

    localparam int VERTEX_SLOTS = 256;
    localparam int COORD_WIDTH = 16;
    localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int RUN_LIMIT = 1500000;
    localparam int REPORT_LIMIT = 10;
    localparam int DIRECTED_ROWS = 25;

    // One input beat, split into its fields.
    typedef struct {
        logic [OPCODE_BITS-1:0] op;
        logic [15:0] vx;
        logic [15:0] vy;
        logic last;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
    } op_beat_t;

    typedef struct packed {
        logic hit;
        logic status;
    } hit_result_t;

    // A hand-written expectation, used only where one is given.
    typedef struct {
        bit typed;
        hit_result_t value;
    } typed_note_t;

    typedef struct {
        logic [OPCODE_BITS-1:0] op;
        int vx;
        int vy;
        bit last;
        int sx;
        int sy;
        int ex;
        int ey;
        bit typed;
        bit hit;
        bit status;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [6*FIELD_BITS-1:0] s_axis_tdata;
    logic [OPCODE_BITS-1:0] s_axis_tuser;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [7:0] m_axis_tdata;

    // Predictor copy of the vertex store.
    logic signed [15:0] ring_x [VERTEX_SLOTS];
    logic signed [15:0] ring_y [VERTEX_SLOTS];
    bit ring_end [VERTEX_SLOTS];
    int vertex_count;

    hit_result_t pending_results[$];
    typed_note_t typed_notes[$];

    int fail_count;
    int items_sent;
    int gen_vertices;
    int traffic_mode;
    bit backpressure_hold;

    // Directed steps: typed expectations only where they are obvious.
    step_row_t directed_steps [DIRECTED_ROWS] = '{
        // Query against the empty store after reset.
        '{OP_QUERY, 0, 0, 0, -10, 0, 10, 0, 1, 0, 0},
        // Square from (0,0) to (100,100).
        '{OP_APPEND, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_APPEND, 100, 0, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_APPEND, 100, 100, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_APPEND, 0, 100, 1, 0, 0, 0, 0, 1, 0, 0},
        // Crossing the right side with a flat segment.
        '{OP_QUERY, 0, 0, 0, 50, 50, 150, 50, 0, 0, 0},
        '{OP_QUERY, 0, 0, 0, 50, 50, 60, 60, 0, 0, 0},
        '{OP_QUERY, 0, 0, 0, 100, -50, 100, 150, 0, 0, 0},
        '{OP_QUERY, 0, 0, 0, 50, -20, 50, 120, 0, 0, 0},
        '{OP_QUERY, 0, 0, 0, -50, -50, 150, 150, 0, 0, 0},
        // Unused opcode with every bit set.
        '{OP_UNUSED, -1, -1, 1, -1, -1, -1, -1, 1, 0, 0},
        // Square at the coordinate extremes.
        '{OP_APPEND, -32768, -32768, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_APPEND, 32767, -32768, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_APPEND, 32767, 32767, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_APPEND, -32768, 32767, 1, 0, 0, 0, 0, 1, 0, 0},
        '{OP_QUERY, 0, 0, 0, -32768, -32768, 32767, 32767, 0, 0, 0},
        '{OP_QUERY, 0, 0, 0, 32767, 1, -32768, 0, 0, 0, 0},
        // Polygon of two coincident vertices: a degenerate edge.
        '{OP_APPEND, 5, 5, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_APPEND, 5, 5, 1, 0, 0, 0, 0, 1, 0, 0},
        '{OP_QUERY, 0, 0, 0, 0, 0, 10, 10, 0, 0, 0},
        // Unclosed tail that a query passes straight through.
        '{OP_APPEND, 200, -10, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_APPEND, 200, 10, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_QUERY, 0, 0, 0, 150, 0, 250, 0, 0, 0, 0},
        // Clear, then the first crossing query again.
        '{OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
        '{OP_QUERY, 0, 0, 0, 50, 50, 150, 50, 1, 0, 0}
    };

    segment_rectilinear_polygon_hit_unit #(
        .MAX_POINTS(VERTEX_SLOTS),
        .COORD_BITS(COORD_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Tests one axis-aligned edge at position pu on its fixed axis, spanning
    // pv..qv on the other, against a segment from (au, av) along (du, dv).
    function automatic bit axis_edge_crossed(longint pu, longint pv, longint qv,
                                             longint au, longint av,
                                             longint du, longint dv);
        longint t;
        longint s1;
        longint s2;
        t = pu - au;
        if (du > 0)
        begin
            if (!(t > 0 && t < du))
                return 1'b0;
        end
        else if (du < 0)
        begin
            if (!(t < 0 && t > du))
                return 1'b0;
        end
        else
            return 1'b0;
        // Cross-multiplied position of the crossing against each edge end.
        s1 = (pv - av) * du - t * dv;
        s2 = (qv - av) * du - t * dv;
        return (s1 > 0 && s2 < 0) || (s1 < 0 && s2 > 0);
    endfunction

    function automatic bit edge_crossed(int i, int k, longint ax, longint ay,
                                        longint dx, longint dy);
        longint px;
        longint py;
        longint qx;
        longint qy;
        px = ring_x[i];
        py = ring_y[i];
        qx = ring_x[k];
        qy = ring_y[k];
        if (px == qx)
            return axis_edge_crossed(px, py, qy, ax, ay, dx, dy);
        if (py == qy)
            return axis_edge_crossed(py, px, qx, ay, ax, dy, dx);
        return 1'b0;
    endfunction

    // Applies one beat to the store copy and returns the result it causes.
    function automatic hit_result_t predict_hit(op_beat_t b);
        hit_result_t r;
        longint ax;
        longint ay;
        longint dx;
        longint dy;
        int ring_start;
        int nxt;
        r = '0;
        case (b.op)
            OP_CLEAR:
                vertex_count = 0;
            OP_APPEND:
                if (vertex_count >= VERTEX_SLOTS)
                    r.status = 1'b1;
                else
                begin
                    ring_x[vertex_count] = b.vx;
                    ring_y[vertex_count] = b.vy;
                    ring_end[vertex_count] = b.last;
                    vertex_count++;
                end
            OP_QUERY:
            begin
                ax = longint'($signed(b.sx));
                ay = longint'($signed(b.sy));
                dx = longint'($signed(b.ex)) - ax;
                dy = longint'($signed(b.ey)) - ay;
                ring_start = 0;
                // Each marked vertex closes the ring that began after the last one.
                for (int j = 0; j < vertex_count; j++)
                begin
                    if (ring_end[j])
                    begin
                        for (int k = ring_start; k <= j; k++)
                        begin
                            nxt = (k < j) ? k + 1 : ring_start;
                            if (edge_crossed(k, nxt, ax, ay, dx, dy))
                                r.hit = 1'b1;
                        end
                        ring_start = j + 1;
                    end
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Input monitor: every accepted beat adds one expected result.
    task automatic record_accepted_beat();
        op_beat_t b;
        hit_result_t r;
        typed_note_t note;
        b.op = s_axis_tuser;
        b.last = s_axis_tlast;
        b.vx = s_axis_tdata[15:0];
        b.vy = s_axis_tdata[31:16];
        b.sx = s_axis_tdata[47:32];
        b.sy = s_axis_tdata[63:48];
        b.ex = s_axis_tdata[79:64];
        b.ey = s_axis_tdata[95:80];
        r = predict_hit(b);
        if (typed_notes.size() != 0)
        begin
            note = typed_notes.pop_front();
            if (note.typed)
                r = note.value;
        end
        pending_results.push_back(r);
    endtask

    // Output monitor: compares each result beat with the oldest expectation.
    task automatic check_result_beat(logic [7:0] data);
        hit_result_t want;
        if (pending_results.size() == 0)
        begin
            report_failure($sformatf("unexpected result beat, data 0x%02h", data));
            return;
        end
        want = pending_results.pop_front();
        if (data[0] !== want.hit)
            report_failure($sformatf("hit mismatch: expected %b, got %b",
                                     want.hit, data[0]));
        if (data[1] !== want.status)
            report_failure($sformatf("status mismatch: expected %b, got %b",
                                     want.status, data[1]));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            record_accepted_beat();
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result_beat(m_axis_tdata);
    end

    // Receiver: random stalls per traffic mode, plus the long hold-off.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= !backpressure_hold &&
                             ($urandom_range(99) >= recv_idle_pct(traffic_mode));
        end
    end

    // One long output stall early in the no-idle mode; the sender keeps going.
    initial
    begin
        int held;
        backpressure_hold = 1'b0;
        wait (traffic_mode == 2);
        repeat (20) @(posedge clk);
        backpressure_hold = 1'b1;
        held = 0;
        while (held < HOLD_OFF_CYCLES)
        begin
            @(posedge clk);
            held++;
        end
        backpressure_hold = 1'b0;
    end

    // Watchdog.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic int send_idle_pct(int mode);
        return (mode == 0) ? 18 : (mode == 1) ? 88 : 0;
    endfunction

    function automatic int recv_idle_pct(int mode);
        return (mode == 0) ? 88 : (mode == 1) ? 18 : 0;
    endfunction

    // Small span keeps polygons and segments close enough to cross often;
    // a span of zero draws from the full coordinate range.
    function automatic logic [15:0] pick_coord(int span);
        if ($urandom_range(19) == 0)
            return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
        if (span == 0)
            return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    function automatic op_beat_t random_beat(logic [OPCODE_BITS-1:0] op);
        op_beat_t b;
        b.op = op;
        b.vx = 16'($urandom);
        b.vy = 16'($urandom);
        b.last = 1'($urandom_range(1));
        b.sx = 16'($urandom);
        b.sy = 16'($urandom);
        b.ex = 16'($urandom);
        b.ey = 16'($urandom);
        return b;
    endfunction

    // Offers one beat after a random gap and returns once it is accepted.
    task automatic send_beat(op_beat_t b, bit typed, hit_result_t typed_value);
        typed_note_t note;
        while ($urandom_range(99) < send_idle_pct(traffic_mode))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        note.typed = typed;
        note.value = typed_value;
        typed_notes.push_back(note);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= b.op;
        s_axis_tlast <= b.last;
        s_axis_tdata <= {b.ey, b.ex, b.sy, b.sx, b.vy, b.vx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (b.op != OP_UNUSED)
            items_sent++;
        if (b.op == OP_CLEAR)
            gen_vertices = 0;
        else if (b.op == OP_APPEND && gen_vertices < VERTEX_SLOTS)
            gen_vertices++;
    endtask

    task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic last);
        op_beat_t b;
        b = random_beat(OP_APPEND);
        b.vx = x;
        b.vy = y;
        b.last = last;
        send_beat(b, 1'b0, '0);
    endtask

    task automatic send_clear();
        send_beat(random_beat(OP_CLEAR), 1'b0, '0);
    endtask

    task automatic send_query(int span);
        op_beat_t b;
        b = random_beat(OP_QUERY);
        b.sx = pick_coord(span);
        b.sy = pick_coord(span);
        b.ex = pick_coord(span);
        b.ey = pick_coord(span);
        // Some segments with no extent along one axis.
        if ($urandom_range(7) == 0)
            b.ex = b.sx;
        else if ($urandom_range(7) == 0)
            b.ey = b.sy;
        send_beat(b, 1'b0, '0);
    endtask

    // Closed rectilinear polygon of 2*pairs vertices, alternating x and y moves.
    task automatic send_rect_polygon(int pairs, int span);
        logic [15:0] xs [6];
        logic [15:0] ys [6];
        for (int i = 0; i < pairs; i++)
        begin
            xs[i] = pick_coord(span);
            ys[i] = pick_coord(span);
        end
        for (int i = 0; i < pairs; i++)
        begin
            send_vertex(xs[i], ys[i], 1'b0);
            send_vertex(xs[(i + 1) % pairs], ys[i], i == pairs - 1);
        end
    endtask

    // Fills the store with small rectangles past its capacity, then queries it.
    task automatic fill_store();
        int bx;
        int by;
        int w;
        int h;
        send_clear();
        for (int i = 0; i < VERTEX_SLOTS + 6; i++)
        begin
            if (i % 4 == 0)
            begin
                bx = $urandom_range(600) - 300;
                by = $urandom_range(600) - 300;
                w = $urandom_range(80, 1);
                h = $urandom_range(80, 1);
            end
            case (i % 4)
                0: send_vertex(16'(bx), 16'(by), 1'b0);
                1: send_vertex(16'(bx + w), 16'(by), 1'b0);
                2: send_vertex(16'(bx + w), 16'(by + h), 1'b0);
                default: send_vertex(16'(bx), 16'(by + h), 1'b1);
            endcase
        end
        repeat (4) send_query(400);
        send_clear();
    endtask

    // Mostly well-formed polygons followed by queries; the rest is noise.
    task automatic run_random_phase();
        int phase_start;
        int pick;
        int n;
        phase_start = items_sent;
        while (items_sent - phase_start < ITEMS_PER_PHASE)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                send_clear();
            else if (pick < 35)
            begin
                if (gen_vertices > 220)
                    send_clear();
                send_rect_polygon($urandom_range(6, 2),
                                  ($urandom_range(9) == 0) ? 0 : 300);
            end
            else if (pick < 82)
            begin
                n = $urandom_range(4, 1);
                repeat (n) send_query(($urandom_range(9) == 0) ? 0 : 400);
            end
            else if (pick < 90)
            begin
                // Unclosed tail: joins whatever polygon is closed next.
                n = $urandom_range(3, 1);
                repeat (n) send_vertex(pick_coord(300), pick_coord(300), 1'b0);
            end
            else if (pick < 96)
            begin
                // Polygon with random, mostly diagonal edges.
                n = $urandom_range(5, 3);
                for (int i = 0; i < n; i++)
                    send_vertex(pick_coord(300), pick_coord(300), i == n - 1);
            end
            else
                send_beat(random_beat(2'($urandom_range(3))), 1'b0, '0);
        end
    endtask

    initial
    begin
        op_beat_t b;
        hit_result_t typed_value;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_CLEAR;
        s_axis_tlast = 1'b0;
        fail_count = 0;
        items_sent = 0;
        gen_vertices = 0;
        vertex_count = 0;
        traffic_mode = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_steps[i])
        begin
            b.op = directed_steps[i].op;
            b.vx = 16'(directed_steps[i].vx);
            b.vy = 16'(directed_steps[i].vy);
            b.last = directed_steps[i].last;
            b.sx = 16'(directed_steps[i].sx);
            b.sy = 16'(directed_steps[i].sy);
            b.ex = 16'(directed_steps[i].ex);
            b.ey = 16'(directed_steps[i].ey);
            typed_value.hit = directed_steps[i].hit;
            typed_value.status = directed_steps[i].status;
            send_beat(b, directed_steps[i].typed, typed_value);
        end

        // Random traffic under each idle pattern.
        for (int mode = 0; mode < 3; mode++)
        begin
            traffic_mode = mode;
            if (mode == 1)
                fill_store();
            run_random_phase();
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then give any stray beat time to show up.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (VERTEX_SLOTS + 4 * DRAIN_CYCLES + 16) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
